// File: rtl/aged_block_swap_cache_macros.svh
// assertion macros for the aged block swap cache
// each macro expects clk and rst_n in the scope where it is used
`ifndef AGED_BLOCK_SWAP_CACHE_MACROS_SVH
`define AGED_BLOCK_SWAP_CACHE_MACROS_SVH
`ifndef SYNTH
`define ABSC_ASSERT_HOLDS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("abscache check failed");
`define ABSC_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("abscache check failed");
`define ABSC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("abscache check failed");
`else
`define ABSC_ASSERT_HOLDS(lbl, expr)
`define ABSC_ASSERT_IMPLIES(lbl, ante, cons)
`define ABSC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/abscache_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package abscache_pkg;

  localparam int NUM_SLOTS  = 8;
  localparam int AGE_W      = 16;
  localparam int TAG_W      = 32;
  localparam int SLOT_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W      = SLOT_W + 1;
  localparam int BASE_W     = 4;
  localparam int CMP_W      = (CNT_W > BASE_W) ? CNT_W : BASE_W;
  localparam int OP_W       = 2;
  localparam int SEL_W      = 3;
  localparam int OUT_SLOT_W = 3;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
  localparam logic [OP_W-1:0] OP_FORCE = 2'd2;

  localparam logic REG_UNLOCKED_BASE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic              tag_en;
    logic              age_en;
    logic [SLOT_W-1:0] idx;
    logic [TAG_W-1:0]  tag;
    logic [AGE_W-1:0]  age;
  } store_wr_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic             valid;
    logic [AGE_W-1:0] age;
  } store_rd_t;

  typedef struct packed {
    logic             tag_match;
    logic             age_ge;
    logic             age_max;
    logic [AGE_W-1:0] age_inc;
  } unit_res_t;

endpackage
`default_nettype wire

// File: rtl/abscache_store.sv
`timescale 1ns / 1ps
`default_nettype none
module abscache_store (
  input  logic                             clk,
  input  logic                             rst_n,
  input  abscache_pkg::store_wr_t          wr,
  input  logic [abscache_pkg::SLOT_W-1:0]  rd_idx,
  output abscache_pkg::store_rd_t          rd
);
  import abscache_pkg::*;

  logic [TAG_W-1:0]     tag_r [NUM_SLOTS];
  logic [AGE_W-1:0]     age_r [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        tag_r[i] <= '0;
        age_r[i] <= '0;
      end
    end else begin
      if (wr.tag_en) begin
        tag_r[wr.idx]   <= wr.tag;
        valid_r[wr.idx] <= 1'b1;
      end
      if (wr.age_en) begin
        age_r[wr.idx] <= wr.age;
      end
    end
  end

  // single read port at the scan index
  assign rd.tag   = tag_r[rd_idx];
  assign rd.valid = valid_r[rd_idx];
  assign rd.age   = age_r[rd_idx];

endmodule
`default_nettype wire

// File: rtl/abscache_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module abscache_unit (
  input  logic [abscache_pkg::TAG_W-1:0] key_tag,
  input  abscache_pkg::store_rd_t        rd,
  input  logic [abscache_pkg::AGE_W-1:0] best_age,
  output abscache_pkg::unit_res_t        res
);
  import abscache_pkg::*;

  // one tag compare, one age compare and a saturating increment, reused every slot
  assign res.tag_match = rd.valid && (rd.tag == key_tag);
  assign res.age_ge    = (rd.age >= best_age);
  assign res.age_max   = &rd.age;
  assign res.age_inc   = res.age_max ? rd.age : rd.age + AGE_W'(1);

endmodule
`default_nettype wire

// File: rtl/aged_block_swap_cache.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative slot cache of NUM_SLOTS entries tagged by source address, with
// oldest-age replacement. A load transaction walks every slot once, one slot per
// cycle through a single shared compare unit, then a commit step writes the store and
// places the result in the output register. A tick walks the slots the same way,
// ageing unlocked ones. A force load and the unused op skip the walk and go straight
// to the commit step. in_stall is high from acceptance until the result has been
// placed in the output register, and a new transaction is taken while that result
// still waits for the sink; the commit step of that next transaction then waits, as
// long as out_stall holds the earlier result, until the output register is free.
// Slots below unlocked_base are locked: they are still searched but never chosen as
// a miss victim or aged, though a force load may still write one. A miss with no
// unlocked slot, or a force load naming a slot past the end, reports error with slot
// zero.
module aged_block_swap_cache (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // input transaction
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [abscache_pkg::OP_W-1:0]         in_op,
  input  logic [31:0]                           in_tag_address,
  input  logic [abscache_pkg::SEL_W-1:0]        in_slot_select,
  // result transaction
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [abscache_pkg::OUT_SLOT_W-1:0]   out_slot,
  output logic                                  out_hit,
  output logic                                  out_load_needed,
  output logic                                  out_error,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [abscache_pkg::ADDR_W-1:0]       paddr,
  input  logic [abscache_pkg::DATA_W-1:0]       pwdata,
  output logic [abscache_pkg::DATA_W-1:0]       prdata,
  output logic                                  pready
);
  import abscache_pkg::*;

  `include "aged_block_swap_cache_macros.svh"

  // sequencer state
  state_t state_r, state_nxt;

  // captured transaction
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [TAG_W-1:0]  key_r, key_nxt;
  logic [SEL_W-1:0]  sel_r, sel_nxt;

  // slot walk
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              hit_found_r, hit_found_nxt;
  logic [SLOT_W-1:0] hit_idx_r, hit_idx_nxt;
  logic              vic_found_r, vic_found_nxt;
  logic              vic_empty_r, vic_empty_nxt;
  logic [SLOT_W-1:0] vic_idx_r, vic_idx_nxt;
  logic [AGE_W-1:0]  best_age_r, best_age_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic                  out_hit_r, out_hit_nxt;
  logic                  out_ld_r, out_ld_nxt;
  logic                  out_err_r, out_err_nxt;

  // lock boundary register
  logic [BASE_W-1:0] base_r;

  logic [SLOT_W-1:0] scan_idx;
  logic              in_range;
  store_wr_t         store_wr;
  store_rd_t         store_rd;
  unit_res_t         unit_res;

  assign scan_idx = cnt_r[SLOT_W-1:0];
  assign in_range = (CMP_W'(cnt_r) >= CMP_W'(base_r));

  abscache_store u_store (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (store_wr),
    .rd_idx (scan_idx),
    .rd     (store_rd)
  );

  abscache_unit u_unit (
    .key_tag  (key_r),
    .rd       (store_rd),
    .best_age (best_age_r),
    .res      (unit_res)
  );

  // configuration: one register, index taken from the word address bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (paddr[ADDR_W-1] == REG_UNLOCKED_BASE)) begin
      base_r <= pwdata[BASE_W-1:0];
    end
  end

  assign prdata = (paddr[ADDR_W-1] == REG_UNLOCKED_BASE) ? DATA_W'(base_r) : '0;
  assign pready = 1'b1;

  // only idle takes a new transaction, even while a result still waits
  assign in_stall = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and walk registers, no reset needed
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    key_r       <= key_nxt;
    sel_r       <= sel_nxt;
    cnt_r       <= cnt_nxt;
    hit_found_r <= hit_found_nxt;
    hit_idx_r   <= hit_idx_nxt;
    vic_found_r <= vic_found_nxt;
    vic_empty_r <= vic_empty_nxt;
    vic_idx_r   <= vic_idx_nxt;
    best_age_r  <= best_age_nxt;
    out_slot_r  <= out_slot_nxt;
    out_hit_r   <= out_hit_nxt;
    out_ld_r    <= out_ld_nxt;
    out_err_r   <= out_err_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    sel_nxt       = sel_r;
    cnt_nxt       = cnt_r;
    hit_found_nxt = hit_found_r;
    hit_idx_nxt   = hit_idx_r;
    vic_found_nxt = vic_found_r;
    vic_empty_nxt = vic_empty_r;
    vic_idx_nxt   = vic_idx_r;
    best_age_nxt  = best_age_r;
    out_slot_nxt  = out_slot_r;
    out_hit_nxt   = out_hit_r;
    out_ld_nxt    = out_ld_r;
    out_err_nxt   = out_err_r;
    store_wr      = '0;

    // sink took the pending result
    out_valid_nxt = out_valid_r && out_stall;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt        = in_op;
          key_nxt       = in_tag_address[TAG_W-1:0];
          sel_nxt       = in_slot_select;
          cnt_nxt       = '0;
          hit_found_nxt = 1'b0;
          vic_found_nxt = 1'b0;
          vic_empty_nxt = 1'b0;
          best_age_nxt  = '0;
          state_nxt     = ((in_op == OP_LOAD) || (in_op == OP_TICK)) ? ST_SCAN : ST_FINISH;
        end
      end

      ST_SCAN: begin
        case (op_r)
          OP_LOAD: begin
            // lowest matching slot wins
            if (!hit_found_r && unit_res.tag_match) begin
              hit_found_nxt = 1'b1;
              hit_idx_nxt   = scan_idx;
            end
            // first empty unlocked slot, else oldest with ties to the higher index
            if (in_range && !vic_empty_r) begin
              if (!store_rd.valid) begin
                vic_idx_nxt   = scan_idx;
                vic_found_nxt = 1'b1;
                vic_empty_nxt = 1'b1;
              end else if (!vic_found_r || unit_res.age_ge) begin
                vic_idx_nxt   = scan_idx;
                vic_found_nxt = 1'b1;
                best_age_nxt  = store_rd.age;
              end
            end
          end
          OP_TICK: begin
            if (in_range && !unit_res.age_max) begin
              store_wr.age_en = 1'b1;
              store_wr.idx    = scan_idx;
              store_wr.age    = unit_res.age_inc;
            end
          end
          default: ;
        endcase
        if (cnt_r == CNT_W'(NUM_SLOTS - 1)) begin
          state_nxt = ST_FINISH;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end

      ST_FINISH: begin
        // commit and present the result once the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = '0;
          out_hit_nxt   = 1'b0;
          out_ld_nxt    = 1'b0;
          out_err_nxt   = 1'b0;
          state_nxt     = ST_IDLE;
          case (op_r)
            OP_LOAD: begin
              if (hit_found_r) begin
                store_wr.age_en = 1'b1;
                store_wr.idx    = hit_idx_r;
                store_wr.age    = '0;
                out_slot_nxt    = OUT_SLOT_W'(hit_idx_r);
                out_hit_nxt     = 1'b1;
              end else if (vic_found_r) begin
                store_wr.tag_en = 1'b1;
                store_wr.age_en = 1'b1;
                store_wr.idx    = vic_idx_r;
                store_wr.tag    = key_r;
                store_wr.age    = '0;
                out_slot_nxt    = OUT_SLOT_W'(vic_idx_r);
                out_ld_nxt      = 1'b1;
              end else begin
                out_err_nxt = 1'b1;
              end
            end
            OP_FORCE: begin
              if (CMP_W'(sel_r) >= CMP_W'(NUM_SLOTS)) begin
                out_err_nxt = 1'b1;
              end else begin
                store_wr.tag_en = 1'b1;
                store_wr.age_en = 1'b1;
                store_wr.idx    = SLOT_W'(sel_r);
                store_wr.tag    = key_r;
                store_wr.age    = '0;
                out_slot_nxt    = OUT_SLOT_W'(sel_r);
                out_ld_nxt      = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_hit         = out_hit_r;
  assign out_load_needed = out_ld_r;
  assign out_error       = out_err_r;

  // an accepted transaction always leaves idle
  `ABSC_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, state_r != ST_IDLE)
  // the walk counter stays inside the slot range
  `ABSC_ASSERT_IMPLIES(a_cnt_range, state_r == ST_SCAN, cnt_r < CNT_W'(NUM_SLOTS))
  // a new result only comes out of the commit step
  `ABSC_ASSERT_IMPLIES(a_result_src, $rose(out_valid_r), $past(state_r == ST_FINISH))
  // hit, load and error are exclusive, and error reports slot zero
  `ABSC_ASSERT_IMPLIES(a_flags_excl, out_valid_r,
                       $countones({out_hit_r, out_ld_r, out_err_r}) <= 1)
  `ABSC_ASSERT_IMPLIES(a_err_slot, out_valid_r && out_err_r, out_slot_r == '0)

endmodule
`default_nettype wire

// File: tb/sv/aged_block_swap_cache_tb.sv
`timescale 1ns / 1ps

module aged_block_swap_cache_tb;
  import abscache_pkg::*;

  // op value with no function, must leave the cache untouched
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [ADDR_W-1:0] UNLOCKED_BASE_ADDR = ADDR_W'(4 * REG_UNLOCKED_BASE);
  // the limit sits far above what a correct run needs, even under the heaviest stalls
  localparam int unsigned CYCLE_LIMIT = 100_000;
  localparam int unsigned TAG_POOL_SIZE = 12;
  // lock boundary for each random block, every legal value once, extremes included
  localparam logic [BASE_W-1:0] BASE_PLAN [9] = '{4'd2, 4'd0, 4'd8, 4'd5, 4'd1, 4'd7,
                                                   4'd3, 4'd6, 4'd4};

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [31:0]      tag;
    logic [SEL_W-1:0] sel;
  } cache_item_t;

  typedef struct packed {
    logic [OUT_SLOT_W-1:0] slot;
    logic                  hit;
    logic                  load_needed;
    logic                  error;
  } cache_result_t;

  typedef enum logic {ROW_ITEM, ROW_SET_BASE} row_kind_t;

  // one line of the directed table: either a transaction or a lock boundary change
  typedef struct packed {
    row_kind_t         kind;
    logic [BASE_W-1:0] base;
    cache_item_t       item;
    logic              pinned;
    cache_result_t     want;
  } stim_row_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // block inputs, all known from time zero
  logic                  in_valid = 1'b0;
  logic [OP_W-1:0]       in_op = '0;
  logic [31:0]           in_tag_address = '0;
  logic [SEL_W-1:0]      in_slot_select = '0;
  logic                  out_stall = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [DATA_W-1:0]     pwdata = '0;

  // block outputs
  logic                  in_stall;
  logic                  out_valid;
  logic [OUT_SLOT_W-1:0] out_slot;
  logic                  out_hit;
  logic                  out_load_needed;
  logic                  out_error;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  // typed expectation travelling alongside the transaction on the input side
  logic                  pin_check = 1'b0;
  cache_result_t         pin_result = '0;

  aged_block_swap_cache dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_tag_address  (in_tag_address),
    .in_slot_select  (in_slot_select),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_slot        (out_slot),
    .out_hit         (out_hit),
    .out_load_needed (out_load_needed),
    .out_error       (out_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // shadow copy of the cache contents and the lock boundary
  logic [TAG_W-1:0]  held_tag   [NUM_SLOTS] = '{default: '0};
  logic              held_valid [NUM_SLOTS] = '{default: 1'b0};
  logic [AGE_W-1:0]  held_age   [NUM_SLOTS] = '{default: '0};
  logic [BASE_W-1:0] lock_base = '0;

  cache_result_t pending_results [$];
  logic [31:0]   tag_pool [TAG_POOL_SIZE];

  int unsigned send_gap_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned hits_seen = 0;
  int unsigned reloads_seen = 0;
  int unsigned errors_flagged = 0;
  int unsigned bases_written = 0;

  // works out the result of one transaction and moves the shadow state on
  function automatic cache_result_t predict_lookup(input cache_item_t it);
    cache_result_t    r;
    int               victim;
    logic [AGE_W-1:0] oldest;
    r = '0;
    victim = -1;
    oldest = '0;
    case (it.op)
      OP_LOAD: begin
        // every valid slot is searched, locked ones too; lowest match wins
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (victim < 0 && held_valid[i] && held_tag[i] == it.tag[TAG_W-1:0]) begin
            victim = i;
          end
        end
        if (victim >= 0) begin
          held_age[victim] = '0;
          r.slot = victim[OUT_SLOT_W-1:0];
          r.hit = 1'b1;
          return r;
        end
        // miss: first empty unlocked slot, else the oldest, ties to the highest index
        for (int i = int'(lock_base); i < NUM_SLOTS; i++) begin
          if (!held_valid[i]) begin
            victim = i;
            break;
          end
          if (held_age[i] >= oldest) begin
            oldest = held_age[i];
            victim = i;
          end
        end
        if (victim < 0) begin
          r.error = 1'b1;
        end else begin
          held_tag[victim] = it.tag[TAG_W-1:0];
          held_valid[victim] = 1'b1;
          held_age[victim] = '0;
          r.slot = victim[OUT_SLOT_W-1:0];
          r.load_needed = 1'b1;
        end
      end
      OP_TICK: begin
        // ages saturate at all ones
        for (int i = int'(lock_base); i < NUM_SLOTS; i++) begin
          if (held_age[i] != '1) held_age[i] = held_age[i] + AGE_W'(1);
        end
      end
      OP_FORCE: begin
        if (int'(it.sel) >= NUM_SLOTS) begin
          r.error = 1'b1;
        end else begin
          held_tag[it.sel] = it.tag[TAG_W-1:0];
          held_valid[it.sel] = 1'b1;
          held_age[it.sel] = '0;
          r.slot = OUT_SLOT_W'(it.sel);
          r.load_needed = 1'b1;
        end
      end
      default: begin
        // unused op: nothing changes, all fields zero
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // scoreboard: predict on input acceptance, compare on output acceptance
  // both sides sample the values present just before the rising edge
  always @(posedge clk) begin : scoreboard
    cache_result_t predicted;
    cache_result_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predicted = predict_lookup('{op: in_op, tag: in_tag_address, sel: in_slot_select});
        pending_results.push_back(pin_check ? pin_result : predicted);
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_hit) hits_seen++;
        if (out_load_needed) reloads_seen++;
        if (out_error) errors_flagged++;
        if (pending_results.size() == 0) begin
          $error("result transaction with no expectation waiting: slot %0d", out_slot);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("slot", 32'(want.slot), 32'(out_slot));
          check_field("hit", 32'(want.hit), 32'(out_hit));
          check_field("load_needed", 32'(want.load_needed), 32'(out_load_needed));
          check_field("error", 32'(want.error), 32'(out_error));
        end
      end
    end
  end

  // sink side back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < sink_stall_pct);
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still awaited",
             cycle_count, pending_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // present one transaction and hold it until it is taken
  // valid stays high on return so back-to-back transactions never drop it
  task automatic send_item(input cache_item_t it, input logic pinned,
                           input cache_result_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= it.op;
    in_tag_address <= it.tag;
    in_slot_select <= it.sel;
    pin_check <= pinned;
    pin_result <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    // step past a clock edge first so the scoreboard has logged the last transaction taken
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // write the lock boundary once the cache is idle, then read it back
  task automatic set_unlocked_base(input logic [BASE_W-1:0] value);
    drain_results();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= UNLOCKED_BASE_ADDR;
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    lock_base = value;
    bases_written++;
    // read-back: setup then access
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("prdata", DATA_W'(value), prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic cache_item_t random_item();
    cache_item_t it;
    int unsigned roll;
    roll = $urandom_range(99);
    it.tag = $urandom();
    it.sel = SEL_W'($urandom_range(7));
    if (roll < 55) it.op = OP_LOAD;
    else if (roll < 80) it.op = OP_TICK;
    else if (roll < 95) it.op = OP_FORCE;
    else it.op = OP_UNUSED;
    // most loads and force loads reuse a small set of tags so hits keep happening
    if (it.op != OP_TICK && $urandom_range(3) != 0) begin
      it.tag = tag_pool[$urandom_range(TAG_POOL_SIZE - 1)];
    end
    return it;
  endfunction

  function automatic stim_row_t item_row(input logic [OP_W-1:0] op, input logic [31:0] tag,
                                         input logic [SEL_W-1:0] sel);
    stim_row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.op = op;
    r.item.tag = tag;
    r.item.sel = sel;
    return r;
  endfunction

  function automatic stim_row_t pinned_row(input logic [OP_W-1:0] op, input logic [31:0] tag,
                                           input logic [SEL_W-1:0] sel,
                                           input logic [OUT_SLOT_W-1:0] slot,
                                           input int hit, input int load_needed,
                                           input int error);
    stim_row_t r;
    r = item_row(op, tag, sel);
    r.pinned = 1'b1;
    r.want.slot = slot;
    r.want.hit = hit[0];
    r.want.load_needed = load_needed[0];
    r.want.error = error[0];
    return r;
  endfunction

  function automatic stim_row_t base_row(input logic [BASE_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_SET_BASE;
    r.base = value;
    return r;
  endfunction

  initial begin
    stim_row_t   directed_rows [$];

    tag_pool[0] = '0;
    tag_pool[1] = '1;
    for (int i = 2; i < TAG_POOL_SIZE; i++) tag_pool[i] = $urandom();

    // directed table: op, tag, slot select, then the typed result where obvious
    directed_rows.push_back(base_row(4'd0));
    // empty slots never match, even on the all-zero reset tag
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h0000_0000, 3'd0, 3'd0, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'hffff_ffff, 3'd7, 3'd1, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h0000_0000, 3'd0, 3'd0, 1, 0, 0));
    // tick also ages the empty unlocked slots
    directed_rows.push_back(pinned_row(OP_TICK, 32'hffff_ffff, 3'd7, 3'd0, 0, 0, 0));
    directed_rows.push_back(pinned_row(OP_UNUSED, 32'hffff_ffff, 3'd7, 3'd0, 0, 0, 0));
    directed_rows.push_back(pinned_row(OP_FORCE, 32'h1234_5678, 3'd7, 3'd7, 0, 1, 0));
    // duplicate tag by force load, search then returns the lowest copy
    directed_rows.push_back(pinned_row(OP_FORCE, 32'hffff_ffff, 3'd5, 3'd5, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'hffff_ffff, 3'd0, 3'd1, 1, 0, 0));
    // fill the remaining empty slots in index order
    directed_rows.push_back(pinned_row(OP_LOAD, 32'ha5a5_a5a5, 3'd0, 3'd2, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h5a5a_5a5a, 3'd0, 3'd3, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h0000_0001, 3'd0, 3'd4, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h8000_0000, 3'd0, 3'd6, 0, 1, 0));
    // full cache: oldest slot goes first, then a tie across the rest
    directed_rows.push_back(item_row(OP_TICK, 32'h0, 3'd0));
    directed_rows.push_back(item_row(OP_LOAD, 32'h0f0f_0f0f, 3'd0));
    directed_rows.push_back(item_row(OP_LOAD, 32'hf0f0_f0f0, 3'd0));
    // everything locked: a miss errors, a hit still works, force load still allowed
    directed_rows.push_back(base_row(4'd8));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h1357_2468, 3'd0, 3'd0, 0, 0, 1));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'ha5a5_a5a5, 3'd0, 3'd2, 1, 0, 0));
    directed_rows.push_back(pinned_row(OP_TICK, 32'h0, 3'd0, 3'd0, 0, 0, 0));
    directed_rows.push_back(pinned_row(OP_FORCE, 32'h2468_ace0, 3'd3, 3'd3, 0, 1, 0));
    // partial lock
    directed_rows.push_back(base_row(4'd5));
    directed_rows.push_back(item_row(OP_TICK, 32'h0, 3'd0));
    directed_rows.push_back(item_row(OP_LOAD, 32'h5a5a_5a5a, 3'd0));
    directed_rows.push_back(pinned_row(OP_FORCE, 32'h0000_0000, 3'd0, 3'd0, 0, 1, 0));
    directed_rows.push_back(pinned_row(OP_LOAD, 32'h0000_0000, 3'd0, 3'd0, 1, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed part runs with light sender gaps and heavy sink stalls
    send_gap_pct = 15;
    sink_stall_pct = 61;
    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_SET_BASE) begin
        set_unlocked_base(directed_rows[k].base);
      end else begin
        send_item(directed_rows[k].item, directed_rows[k].pinned, directed_rows[k].want);
      end
    end

    // random part: three idling regimes, three lock boundaries in each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_gap_pct = 15;
          sink_stall_pct = 61;
        end
        1: begin
          send_gap_pct = 61;
          sink_stall_pct = 15;
        end
        default: begin
          send_gap_pct = 0;
          sink_stall_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        set_unlocked_base(BASE_PLAN[ph * 3 + blk]);
        repeat (45) begin
          // now and then let the cache run completely dry
          if ($urandom_range(24) == 0) drain_results();
          send_item(random_item(), 1'b0, '0);
        end
      end
    end

    drain_results();
    // anything arriving now is an unexpected result
    repeat (4 * (NUM_SLOTS + 2)) @(posedge clk);

    $display("covered %0d results: %0d hits, %0d reloads, %0d lock errors",
             results_seen, hits_seen, reloads_seen, errors_flagged);
    $display("lock boundary written %0d times, %0d cycles, %0d mismatches",
             bases_written, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
